FILE: src/sce_pkg.sv
// shared types, codes and constants of the seam carving engine
package sce_pkg;

	localparam int COST_W    = 18;
	localparam int CNT_W     = 9;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam logic [COST_W-1:0] COST_SAT = '1;

	localparam int MAX_ROWS_DEF   = 256;
	localparam int MAX_COLS_DEF   = 256;
	localparam int PIXEL_BITS_DEF = 8;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_CARVE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR  = 2'd2;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_CARVE = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] pixel;
	} in_word_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] read_value;
		logic [7:0] seam_end;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RESP, ST_CELL, ST_SCAN, ST_SEAM, ST_SHIFT, ST_BT, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		P0, P1, P2, P3, P4, P5, P6, P7, P8, P9
	} phase_t;

	typedef enum logic [1:0] {
		ALU_ACC, ALU_ADD, ALU_LT
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
	} alu_ctl_t;

endpackage

FILE: src/seam_carving_engine.sv
// seam carving engine top level: image and cost stores, carve sequencer
//
//   channel  | payload     | handshake
//   ---------+-------------+---------------------------------------
//   in       | in_word_t   | in_valid / in_stall (stall from block)
//   out      | out_word_t  | out_valid / out_stall (stall from sink)
//   cfg      | cfg_data    | cfg_we, cfg_index, no wait
//
// pixel write is done in idle; pixel read adds a response state and output wait
// a carve's length is set by one read port per store and the single shared
// arithmetic unit
// reset clears control state only; the stores come up undefined, no clearing pass
// in_stall is high for the whole carve or read; a stalled output word holds

module seam_carving_engine
	import sce_pkg::*;
#(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int AW       = $clog2(DEPTH);
	localparam int ROWS_RST = (MAX_ROWS < 256) ? MAX_ROWS : 256;
	localparam int COLS_RST = (MAX_COLS < 256) ? MAX_COLS : 256;

	// store layout is row major; a horizontal seam swaps line and position
	function automatic logic [AW-1:0] addr_of(logic h, logic [CNT_W-1:0] ln,
		logic [CNT_W-1:0] ps);
		int r;
		int c;
		r = h ? int'(ps) : int'(ln);
		c = h ? int'(ln) : int'(ps);
		return AW'(r * MAX_COLS + c);
	endfunction

	// stores
	logic [PIXEL_BITS-1:0] img_mem [DEPTH];
	logic [COST_W-1:0]     cost_mem [DEPTH];
	logic [PIXEL_BITS-1:0] img_rd_q;
	logic [COST_W-1:0]     cost_rd_q;
	logic                  img_re, img_we, cost_re, cost_we;
	logic [AW-1:0]         img_raddr, img_waddr, cost_raddr, cost_waddr;
	logic [PIXEL_BITS-1:0] img_wdata;
	logic [COST_W-1:0]     cost_wdata;

	always_ff @(posedge clk) begin
		if (img_we) img_mem[img_waddr] <= img_wdata;
		if (img_re) img_rd_q <= img_mem[img_raddr];
	end

	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
		if (cost_re) cost_rd_q <= cost_mem[cost_raddr];
	end

	// configuration, clamped into range on write
	logic [CFG_W-1:0] rows_q, cols_q;
	logic             dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(ROWS_RST);
			cols_q <= CFG_W'(COLS_RST);
			dir_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: begin
					if (cfg_data < CFG_W'(2)) rows_q <= CFG_W'(2);
					else if (32'(cfg_data) > MAX_ROWS) rows_q <= CFG_W'(MAX_ROWS);
					else rows_q <= cfg_data;
				end
				REG_COLS: begin
					if (cfg_data < CFG_W'(2)) cols_q <= CFG_W'(2);
					else if (32'(cfg_data) > MAX_COLS) cols_q <= CFG_W'(MAX_COLS);
					else cols_q <= cfg_data;
				end
				REG_DIR: dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer state and datapath registers
	state_t            state_q, state_d;
	phase_t            ph_q, ph_d;
	logic [CNT_W-1:0]  line_q, line_d, pos_q, pos_d, cur_q, cur_d, nl_q, nl_d, np_q, np_d;
	logic              horiz_q, horiz_d, inside_q, inside_d;
	logic              lo_ok_q, lo_ok_d, hi_ok_q, hi_ok_d;
	logic [PIXEL_BITS-1:0] ctr_q, ctr_d;
	logic [COST_W-1:0] acc_q, acc_d, min_q, min_d, here_q, here_d;
	logic [COST_W-1:0] lo_q, lo_d, hi_q, hi_d, best_q, best_d;
	logic [7:0]        seam_q, seam_d;
	logic              out_valid_q;
	out_word_t         out_q, out_d;
	logic              out_load, out_free;

	// shared unit
	alu_ctl_t          alu_ctl;
	logic [COST_W-1:0] alu_a, alu_b, alu_acc, alu_sum;
	logic              alu_lt;

	sce_alu u_alu (
		.ctl(alu_ctl),
		.a  (alu_a),
		.b  (alu_b),
		.acc(alu_acc),
		.sum(alu_sum),
		.lt (alu_lt)
	);

	// neighbor bounds
	logic upv, dnv, lfv, rtv, has_lo, has_hi, in_inside;
	logic [AW-1:0] pix_addr;
	logic [CNT_W-1:0] new_cur;

	always_comb begin
		upv       = line_q != '0;
		dnv       = (10'(line_q) + 10'd1) < 10'(nl_q);
		lfv       = pos_q != '0;
		rtv       = (10'(pos_q) + 10'd1) < 10'(np_q);
		has_lo    = cur_q != '0;
		has_hi    = (10'(cur_q) + 10'd1) < 10'(np_q);
		in_inside = (32'(in_word.row) < MAX_ROWS) && (32'(in_word.col) < MAX_COLS);
		pix_addr  = in_inside ? addr_of(1'b0, CNT_W'(in_word.row), CNT_W'(in_word.col))
			: '0;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_d  = state_q;
		ph_d     = ph_q;
		line_d   = line_q;
		pos_d    = pos_q;
		cur_d    = cur_q;
		nl_d     = nl_q;
		np_d     = np_q;
		horiz_d  = horiz_q;
		inside_d = inside_q;
		lo_ok_d  = lo_ok_q;
		hi_ok_d  = hi_ok_q;
		ctr_d    = ctr_q;
		acc_d    = acc_q;
		min_d    = min_q;
		here_d   = here_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		best_d   = best_q;
		seam_d   = seam_q;
		out_load = 1'b0;
		out_d    = out_q;
		img_re     = 1'b0;
		img_raddr  = addr_of(horiz_q, line_q, pos_q);
		img_we     = 1'b0;
		img_waddr  = addr_of(horiz_q, line_q, pos_q);
		img_wdata  = img_rd_q;
		cost_re    = 1'b0;
		cost_raddr = addr_of(horiz_q, line_q, pos_q);
		cost_we    = 1'b0;
		cost_waddr = addr_of(horiz_q, line_q, pos_q);
		cost_wdata = acc_q;
		alu_ctl.op = ALU_ACC;
		alu_a      = COST_W'(ctr_q);
		alu_b      = COST_W'(img_rd_q);
		alu_acc    = acc_q;
		new_cur    = cur_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_word.cmd)
						CMD_WRITE: begin
							img_we    = in_inside;
							img_waddr = pix_addr;
							img_wdata = PIXEL_BITS'(in_word.pixel);
						end
						CMD_CARVE: begin
							horiz_d = dir_q;
							nl_d    = dir_q ? cols_q : rows_q;
							np_d    = dir_q ? rows_q : cols_q;
							line_d  = '0;
							pos_d   = '0;
							ph_d    = P0;
							state_d = ST_CELL;
						end
						CMD_READ: begin
							img_re    = 1'b1;
							img_raddr = pix_addr;
							inside_d  = in_inside;
							state_d   = ST_RESP;
						end
						default: ;
					endcase
				end
			end

			ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{kind: KIND_READ,
						read_value: inside_q ? 8'(img_rd_q) : 8'd0, seam_end: 8'd0};
					state_d  = ST_IDLE;
				end
			end

			// one cell: energy from up to four neighbors, then min of up to three above
			ST_CELL: begin
				ph_d = phase_t'(ph_q + 4'd1);
				unique case (ph_q)
					P0: img_re = 1'b1;
					P1: begin
						ctr_d     = img_rd_q;
						acc_d     = '0;
						img_re    = 1'b1;
						img_raddr = addr_of(horiz_q, upv ? line_q - 1'b1 : line_q, pos_q);
					end
					P2: begin
						if (upv) acc_d = alu_sum;
						img_re    = 1'b1;
						img_raddr = addr_of(horiz_q, dnv ? line_q + 1'b1 : line_q, pos_q);
					end
					P3: begin
						if (dnv) acc_d = alu_sum;
						img_re    = 1'b1;
						img_raddr = addr_of(horiz_q, line_q, lfv ? pos_q - 1'b1 : pos_q);
					end
					P4: begin
						if (lfv) acc_d = alu_sum;
						img_re    = 1'b1;
						img_raddr = addr_of(horiz_q, line_q, rtv ? pos_q + 1'b1 : pos_q);
					end
					P5: begin
						if (rtv) acc_d = alu_sum;
						cost_re    = upv;
						cost_raddr = addr_of(horiz_q, upv ? line_q - 1'b1 : line_q, pos_q);
					end
					P6: begin
						min_d      = cost_rd_q;
						cost_re    = 1'b1;
						cost_raddr = addr_of(horiz_q, line_q - 1'b1, lfv ? pos_q - 1'b1 : pos_q);
					end
					P7: begin
						alu_ctl.op = ALU_LT;
						alu_a      = cost_rd_q;
						alu_b      = min_q;
						if (lfv && alu_lt) min_d = cost_rd_q;
						cost_re    = 1'b1;
						cost_raddr = addr_of(horiz_q, line_q - 1'b1, rtv ? pos_q + 1'b1 : pos_q);
					end
					P8: begin
						alu_ctl.op = ALU_LT;
						alu_a      = cost_rd_q;
						alu_b      = min_q;
						if (rtv && alu_lt) min_d = cost_rd_q;
					end
					P9: begin
						alu_ctl.op = ALU_ADD;
						alu_a      = min_q;
						cost_we    = 1'b1;
						cost_wdata = alu_sum;
					end
					default: ;
				endcase
				// first line stores its energy; later lines finish after the add
				if ((ph_q == P6 && !upv) || ph_q == P9) begin
					cost_we = 1'b1;
					if (ph_q == P6) cost_wdata = acc_q;
					ph_d = P0;
					if (rtv) begin
						pos_d = pos_q + 1'b1;
					end else begin
						pos_d = '0;
						if (dnv) line_d = line_q + 1'b1;
						else state_d = ST_SCAN;
					end
				end
			end

			// last line: keep the last minimum
			ST_SCAN: begin
				if (ph_q == P0) begin
					cost_re    = 1'b1;
					cost_raddr = addr_of(horiz_q, nl_q - 1'b1, pos_q);
					ph_d       = P1;
				end else begin
					alu_ctl.op = ALU_LT;
					alu_a      = best_q;
					alu_b      = cost_rd_q;
					if (pos_q == '0 || !alu_lt) begin
						best_d = cost_rd_q;
						cur_d  = pos_q;
					end
					ph_d = P0;
					if (rtv) pos_d = pos_q + 1'b1;
					else state_d = ST_SEAM;
				end
			end

			ST_SEAM: begin
				seam_d  = cur_q[7:0];
				pos_d   = cur_q;
				line_d  = nl_q - 1'b1;
				ph_d    = P0;
				state_d = ST_SHIFT;
			end

			// pull later pixels of the line down by one; last one keeps its value
			ST_SHIFT: begin
				if (ph_q == P0) begin
					if (rtv) begin
						img_re    = 1'b1;
						img_raddr = addr_of(horiz_q, line_q, pos_q + 1'b1);
						ph_d      = P1;
					end else if (line_q == '0) begin
						state_d = ST_DONE;
					end else begin
						line_d  = line_q - 1'b1;
						state_d = ST_BT;
					end
				end else begin
					img_we = 1'b1;
					pos_d  = pos_q + 1'b1;
					ph_d   = P0;
				end
			end

			// step back one line: move only to a strictly cheaper neighbor
			ST_BT: begin
				ph_d = phase_t'(ph_q + 4'd1);
				unique case (ph_q)
					P0: begin
						cost_re    = 1'b1;
						cost_raddr = addr_of(horiz_q, line_q, cur_q);
					end
					P1: begin
						here_d     = cost_rd_q;
						cost_re    = 1'b1;
						cost_raddr = addr_of(horiz_q, line_q, has_lo ? cur_q - 1'b1 : cur_q);
					end
					P2: begin
						lo_d       = cost_rd_q;
						cost_re    = 1'b1;
						cost_raddr = addr_of(horiz_q, line_q, has_hi ? cur_q + 1'b1 : cur_q);
					end
					P3: hi_d = cost_rd_q;
					P4: begin
						alu_ctl.op = ALU_LT;
						alu_a      = lo_q;
						alu_b      = here_q;
						lo_ok_d    = has_lo && alu_lt;
					end
					P5: begin
						alu_ctl.op = ALU_LT;
						alu_a      = hi_q;
						alu_b      = here_q;
						hi_ok_d    = has_hi && alu_lt;
					end
					P6: begin
						alu_ctl.op = ALU_LT;
						alu_a      = hi_q;
						alu_b      = lo_q;
						if (lo_ok_q && hi_ok_q) new_cur = alu_lt ? cur_q + 1'b1 : cur_q - 1'b1;
						else if (lo_ok_q) new_cur = cur_q - 1'b1;
						else if (hi_ok_q) new_cur = cur_q + 1'b1;
						cur_d   = new_cur;
						pos_d   = new_cur;
						ph_d    = P0;
						state_d = ST_SHIFT;
					end
					default: ph_d = P0;
				endcase
			end

			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{kind: KIND_CARVE, read_value: 8'd0, seam_end: seam_q};
					state_d  = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= P0;
			seam_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			seam_q  <= seam_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		line_q   <= line_d;
		pos_q    <= pos_d;
		cur_q    <= cur_d;
		nl_q     <= nl_d;
		np_q     <= np_d;
		horiz_q  <= horiz_d;
		inside_q <= inside_d;
		lo_ok_q  <= lo_ok_d;
		hi_ok_q  <= hi_ok_d;
		ctr_q    <= ctr_d;
		acc_q    <= acc_d;
		min_q    <= min_d;
		here_q   <= here_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		best_q   <= best_d;
		if (out_load) out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// cost store is only written by the cell pass
	a_cost_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cost_we |-> state_q == ST_CELL)
		else $error("cost write outside cell pass");

	// seam column stays inside the active window while shifting and tracing back
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT || state_q == ST_BT) |-> cur_q < np_q)
		else $error("seam index out of window");

	// a finished carve leaves the sequencer idle with a word loaded
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("carve result not delivered");

endmodule

FILE: src/sce_alu.sv
// shared arithmetic unit: absolute difference accumulate, saturating add, compare
module sce_alu
	import sce_pkg::*;
(
	input  alu_ctl_t          ctl,
	input  logic [COST_W-1:0] a,
	input  logic [COST_W-1:0] b,
	input  logic [COST_W-1:0] acc,
	output logic [COST_W-1:0] sum,
	output logic              lt
);

	logic [COST_W-1:0] diff;
	logic [COST_W:0]   raw;

	always_comb begin
		diff = (a > b) ? a - b : b - a;
		unique case (ctl.op)
			ALU_ACC: raw = {1'b0, acc} + {1'b0, diff};
			ALU_ADD: raw = {1'b0, acc} + {1'b0, a};
			ALU_LT:  raw = '0;
			default: raw = '0;
		endcase
		sum = raw[COST_W] ? COST_SAT : raw[COST_W-1:0];
		lt  = a < b;
	end

endmodule
